@@ hw/rtl/decimal_frequency_text_parser_core_macros.svh @@
// ----------------------------------------------------------------------------
// Decimal frequency text parser assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_FREQUENCY_TEXT_PARSER_CORE_MACROS_SVH
`define DECIMAL_FREQUENCY_TEXT_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define DFP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfp assertion failed");
// Next-cycle implication.
`define DFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfp assertion failed");
`else
`define DFP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define DFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/dfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Decimal frequency text parser package
// Shared types, character codes and the power-of-ten table.
// ----------------------------------------------------------------------------
package dfp_pkg;

   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_NINE    = 8'h39;
   localparam logic [7:0]  CHAR_DOT     = 8'h2E;
   localparam logic [7:0]  CHAR_SPACE   = 8'h20;
   localparam logic [7:0]  CHAR_TAB     = 8'h09;
   localparam logic [7:0]  CHAR_CR      = 8'h0D;

   localparam logic [63:0] MHZ_MAX      = 64'd9999;
   localparam int          MHZ_BITS     = 14;
   localparam int          MHZ_HZ_BITS  = 34;
   localparam logic [MHZ_HZ_BITS-1:0] HZ_PER_MHZ = 34'd1000000;
   localparam int          FRAC_BITS    = 20;
   localparam logic [2:0]  FRAC_DIGITS  = 3'd6;
   localparam logic [2:0]  GROUP_DIGITS = 3'd3;

   // Accumulated parse state of one text.
   typedef struct packed {
      logic        failed;
      logic [1:0]  dot_count;
      logic        whole_seen;
      logic [63:0] whole_value;
      logic        whole_overflow;
      logic [2:0]  mid_digits;
      logic [19:0] mid_value;
      logic [2:0]  low_digits;
      logic [9:0]  low_value;
   } scan_type;

   // Scaled terms ready for the final sum.
   typedef struct packed {
      logic                   ok;
      logic                   plain;
      logic [63:0]            whole_value;
      logic [MHZ_HZ_BITS-1:0] whole_hz;
      logic [FRAC_BITS-1:0]   mid_hz;
      logic [FRAC_BITS-1:0]   low_hz;
   } prod_type;

   function automatic logic [FRAC_BITS-1:0] pow10(input logic [2:0] n);
      logic [FRAC_BITS-1:0] r;
      case (n)
         3'd0:    r = 20'd1;
         3'd1:    r = 20'd10;
         3'd2:    r = 20'd100;
         3'd3:    r = 20'd1000;
         3'd4:    r = 20'd10000;
         3'd5:    r = 20'd100000;
         3'd6:    r = 20'd1000000;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

@@ hw/rtl/dfp_scanner.sv @@
// ----------------------------------------------------------------------------
// Decimal frequency text scanner
// Per-byte parse state update; snapshots the final state on the last byte.
// ----------------------------------------------------------------------------
module dfp_scanner (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        char_code,
   input  logic              is_last,
   output logic              in_ready,
   input  logic              snap_ready,
   output logic              snap_valid,
   output dfp_pkg::scan_type snap
);

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_BODY,
      PH_TAIL
   } phase_type;

   phase_type         phase_ff, phase_in;
   dfp_pkg::scan_type st_ff, st_in;
   dfp_pkg::scan_type snap_ff;
   logic              snap_valid_ff, snap_valid_in;

   logic [3:0]  digit;
   logic        is_digit;
   logic [67:0] whole_wide;
   logic [19:0] mid_next;
   logic [9:0]  low_next;

   assign digit    = 4'(char_code - dfp_pkg::CHAR_ZERO);
   assign is_digit = (char_code >= dfp_pkg::CHAR_ZERO) && (char_code <= dfp_pkg::CHAR_NINE);

   // times ten as two shifts and an add
   assign whole_wide = ({4'b0, st_ff.whole_value} << 3) + ({4'b0, st_ff.whole_value} << 1)
                     + 68'(digit);
   assign mid_next   = (st_ff.mid_value << 3) + (st_ff.mid_value << 1) + 20'(digit);
   assign low_next   = (st_ff.low_value << 3) + (st_ff.low_value << 1) + 10'(digit);

   always_comb begin
      st_in    = st_ff;
      phase_in = phase_ff;
      if (!st_ff.failed) begin
         if (dfp_pkg::is_space(char_code)) begin
            if (phase_ff == PH_BODY) phase_in = PH_TAIL;
         end else if (phase_ff == PH_TAIL) begin
            st_in.failed = 1'b1;
         end else begin
            phase_in = PH_BODY;
            if (is_digit) begin
               if (st_ff.dot_count == 2'd0) begin
                  st_in.whole_seen = 1'b1;
                  if (!st_ff.whole_overflow) begin
                     if (whole_wide[67:64] != 4'd0) st_in.whole_overflow = 1'b1;
                     else st_in.whole_value = whole_wide[63:0];
                  end
               end else if (st_ff.dot_count == 2'd1) begin
                  if (st_ff.mid_digits >= dfp_pkg::FRAC_DIGITS) begin
                     st_in.failed = 1'b1;
                  end else begin
                     st_in.mid_value  = mid_next;
                     st_in.mid_digits = st_ff.mid_digits + 3'd1;
                  end
               end else begin
                  if (st_ff.low_digits >= dfp_pkg::GROUP_DIGITS) begin
                     st_in.failed = 1'b1;
                  end else begin
                     st_in.low_value  = low_next;
                     st_in.low_digits = st_ff.low_digits + 3'd1;
                  end
               end
            end else if (char_code == dfp_pkg::CHAR_DOT) begin
               if (!st_ff.whole_seen || st_ff.dot_count >= 2'd2) begin
                  st_in.failed = 1'b1;
               end else if (st_ff.dot_count == 2'd1 && (st_ff.mid_digits == 3'd0 ||
                            st_ff.mid_digits > dfp_pkg::GROUP_DIGITS)) begin
                  st_in.failed = 1'b1;
               end else begin
                  st_in.dot_count = st_ff.dot_count + 2'd1;
               end
            end else begin
               st_in.failed = 1'b1;
            end
         end
      end
   end

   // hold the snapshot until taken; a new last byte refills it
   always_comb begin
      snap_valid_in = snap_valid_ff && !snap_ready;
      if (take && is_last) snap_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEAD;
         st_ff         <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         if (take) begin
            if (is_last) begin
               snap_ff  <= st_in;
               phase_ff <= PH_LEAD;
               st_ff    <= '0;
            end else begin
               phase_ff <= phase_in;
               st_ff    <= st_in;
            end
         end
      end
   end

   assign in_ready   = !snap_valid_ff || snap_ready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

@@ hw/rtl/dfp_scale.sv @@
// ----------------------------------------------------------------------------
// Decimal frequency scaling stage
// Checks the final parse state and scales MHz and fraction groups to hertz.
// ----------------------------------------------------------------------------
module dfp_scale (
   input  logic              clock,
   input  logic              reset,
   input  logic              snap_valid,
   input  dfp_pkg::scan_type snap,
   output logic              snap_ready,
   input  logic              prod_ready,
   output logic              prod_valid,
   output dfp_pkg::prod_type prod
);

   dfp_pkg::prod_type prod_ff, prod_in;
   logic              prod_valid_ff;
   logic              bad_any, too_big, bad_one, bad_two;
   logic [2:0]        mid_shift, low_shift;

   assign bad_any = snap.failed || !snap.whole_seen || snap.whole_overflow;
   assign too_big = snap.whole_value > dfp_pkg::MHZ_MAX;
   assign bad_one = snap.mid_digits == 3'd0 || snap.mid_digits > dfp_pkg::FRAC_DIGITS;
   assign bad_two = snap.mid_digits == 3'd0 || snap.mid_digits > dfp_pkg::GROUP_DIGITS ||
                    snap.low_digits == 3'd0 || snap.low_digits > dfp_pkg::GROUP_DIGITS;

   // mid group weight is 10^(6-digits) in both dotted forms
   assign mid_shift = dfp_pkg::FRAC_DIGITS - snap.mid_digits;
   assign low_shift = dfp_pkg::GROUP_DIGITS - snap.low_digits;

   always_comb begin
      prod_in.plain       = snap.dot_count == 2'd0;
      prod_in.whole_value = snap.whole_value;
      if (bad_any) begin
         prod_in.ok = 1'b0;
      end else if (snap.dot_count == 2'd0) begin
         prod_in.ok = 1'b1;
      end else if (too_big) begin
         prod_in.ok = 1'b0;
      end else if (snap.dot_count == 2'd1) begin
         prod_in.ok = !bad_one;
      end else begin
         prod_in.ok = !bad_two;
      end
      prod_in.whole_hz = dfp_pkg::MHZ_HZ_BITS'(snap.whole_value[dfp_pkg::MHZ_BITS-1:0])
                       * dfp_pkg::HZ_PER_MHZ;
      prod_in.mid_hz   = dfp_pkg::FRAC_BITS'(snap.mid_value * dfp_pkg::pow10(mid_shift));
      prod_in.low_hz   = dfp_pkg::FRAC_BITS'({10'b0, snap.low_value}
                                             * dfp_pkg::pow10(low_shift));
   end

   assign snap_ready = !prod_valid_ff || prod_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         if (snap_ready) begin
            prod_valid_ff <= snap_valid;
            if (snap_valid) prod_ff <= prod_in;
         end
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

endmodule

@@ hw/rtl/decimal_frequency_text_parser_core.sv @@
// ----------------------------------------------------------------------------
// Decimal frequency text parser core
// Parses typed frequency text, one byte per transaction, into hertz.
// ----------------------------------------------------------------------------
// The block takes one byte of frequency text per request transaction and
// accepts a new byte every clock cycle while req_ready is high. Leading
// and trailing whitespace (tab through carriage return, and space) are
// skipped. Plain digits are hertz and must fit 64 bits; "MHz.fraction"
// takes 1 to 6 fraction digits; "MHz.kHz.Hz" takes groups of 1 to 3
// digits; dotted forms limit MHz to 9999. Only the byte flagged
// req_is_last yields a response transaction, carrying rsp_ok and
// rsp_hertz (zero when rsp_ok is low), and the parser is clear for the
// next text on the following cycle. Results are registered as the parse
// state snapshot, scaling products, then the final sum in the output
// register. A stalled response holds the pipeline, so req_ready drops
// only while a finished result waits and both internal stages are full.
`include "decimal_frequency_text_parser_core_macros.svh"

module decimal_frequency_text_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [63:0] rsp_hertz
);

   logic              take;
   logic              snap_valid, snap_ready;
   dfp_pkg::scan_type snap;
   logic              prod_valid, out_free;
   dfp_pkg::prod_type prod;

   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [63:0]       rsp_hertz_ff, rsp_hertz_in;

   assign take = req_valid && req_ready;

   // Stage 1: byte-by-byte parse state, snapshot on the last byte.
   dfp_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .char_code  (req_char_code),
      .is_last    (req_is_last),
      .in_ready   (req_ready),
      .snap_ready (snap_ready),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   // Stage 2: validity check and scaling products.
   dfp_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready),
      .prod_ready (out_free),
      .prod_valid (prod_valid),
      .prod       (prod)
   );

   // Stage 3: sum the terms or pass plain hertz; zero on a failed parse.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (!prod.ok) begin
         rsp_hertz_in = '0;
      end else if (prod.plain) begin
         rsp_hertz_in = prod.whole_value;
      end else begin
         rsp_hertz_in = 64'(prod.whole_hz) + 64'(prod.mid_hz) + 64'(prod.low_hz);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= prod_valid;
            if (prod_valid) begin
               rsp_ok_ff    <= prod.ok;
               rsp_hertz_ff <= rsp_hertz_in;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_hertz = rsp_hertz_ff;

   // A failed parse never reports a nonzero frequency.
   `DFP_ASSERT_IMPLIES(a_zero_on_fail, clock, reset, rsp_valid_ff && !rsp_ok_ff,
      rsp_hertz_ff == 64'd0)
   // The last byte always produces a snapshot for the scaling stage.
   `DFP_ASSERT_NEXT(a_last_snaps, clock, reset, take && req_is_last, snap_valid)
   // A scaled result held back by a stalled output is not lost.
   `DFP_ASSERT_NEXT(a_prod_holds, clock, reset, prod_valid && !out_free, prod_valid)

endmodule

@@ verif/decimal_frequency_text_parser_core_test.sv @@
// ----------------------------------------------------------------------------
// Decimal frequency text parser core testbench
// Streams typed frequency texts into the parser one byte per transaction and
// checks every response against an independent in-bench text scanner.
// ----------------------------------------------------------------------------
module decimal_frequency_text_parser_core_test;

   // Stop when this many cycles pass with no transaction on either channel.
   localparam int          QUIET_LIMIT = 2000;
   localparam int          LONG_HOLD   = 150;
   localparam int          CALM_TAIL   = 60;
   localparam logic [63:0] HZ_PER_KHZ  = 64'd1000;
   localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {SCAN_LEAD, SCAN_BODY, SCAN_TAIL} scan_phase_type;

   // Running state of the text being typed.
   typedef struct {
      scan_phase_type phase;
      logic           failed;
      logic [1:0]     dots;
      logic           whole_seen;
      logic [63:0]    whole;
      logic           whole_ovf;
      logic [2:0]     mid_n;
      logic [19:0]    mid;
      logic [2:0]     low_n;
      logic [9:0]     low;
   } text_scan_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] hertz;
   } reading_type;

   // One queued byte; hold marks the first byte of a text that waits for
   // every earlier reading to come back before it is offered.
   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       hold;
   } text_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ok;
   logic [63:0] rsp_hertz;

   text_byte_type typed_bytes[$];
   reading_type   awaited_readings[$];
   logic [7:0]    draft[$];
   text_scan_type scan;

   logic        req_took = 1'b0;
   int          mismatch_count = 0;
   int          readings_seen = 0;
   int          quiet_cycles = 0;
   int          gap_left = 0;
   int          gap_pct = 0;
   int          stall_left = 0;
   int          stall_pct = 0;
   int          hold_left = 0;
   logic        long_hold_done = 1'b0;

   decimal_frequency_text_parser_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ok        (rsp_ok),
      .rsp_hertz     (rsp_hertz)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Text scanner: tracks the parse of the current text byte by byte.
   // ------------------------------------------------------------------------
   function automatic text_scan_type blank_scan();
      text_scan_type s;
      s.phase      = SCAN_LEAD;
      s.failed     = 1'b0;
      s.dots       = 2'd0;
      s.whole_seen = 1'b0;
      s.whole      = 64'd0;
      s.whole_ovf  = 1'b0;
      s.mid_n      = 3'd0;
      s.mid        = 20'd0;
      s.low_n      = 3'd0;
      s.low        = 10'd0;
      return s;
   endfunction

   function automatic logic [63:0] ten_to(input int n);
      logic [63:0] p;
      p = 64'd1;
      repeat (n) p = p * 64'd10;
      return p;
   endfunction

   task automatic scan_char(input logic [7:0] c);
      logic [63:0] d;
      logic        blank;
      blank = (c == dfp_pkg::CHAR_SPACE) ||
              (c >= dfp_pkg::CHAR_TAB && c <= dfp_pkg::CHAR_CR);
      // A failed text ignores everything up to its last byte.
      if (scan.failed)
         return;
      if (blank) begin
         if (scan.phase == SCAN_BODY)
            scan.phase = SCAN_TAIL;
         return;
      end
      // Anything visible after trailing whitespace is inner whitespace.
      if (scan.phase == SCAN_TAIL) begin
         scan.failed = 1'b1;
         return;
      end
      scan.phase = SCAN_BODY;
      if (c >= dfp_pkg::CHAR_ZERO && c <= dfp_pkg::CHAR_NINE) begin
         d = 64'(c - dfp_pkg::CHAR_ZERO);
         if (scan.dots == 2'd0) begin
            scan.whole_seen = 1'b1;
            if (!scan.whole_ovf) begin
               if (scan.whole > (ALL_ONES - d) / 64'd10)
                  scan.whole_ovf = 1'b1;
               else
                  scan.whole = scan.whole * 64'd10 + d;
            end
         end else if (scan.dots == 2'd1) begin
            if (scan.mid_n >= dfp_pkg::FRAC_DIGITS) begin
               scan.failed = 1'b1;
            end else begin
               scan.mid   = scan.mid * 20'd10 + d[19:0];
               scan.mid_n = scan.mid_n + 3'd1;
            end
         end else begin
            if (scan.low_n >= dfp_pkg::GROUP_DIGITS) begin
               scan.failed = 1'b1;
            end else begin
               scan.low   = scan.low * 10'd10 + d[9:0];
               scan.low_n = scan.low_n + 3'd1;
            end
         end
      end else if (c == dfp_pkg::CHAR_DOT) begin
         // A dot needs a whole part; the second one closes a kHz group.
         if (!scan.whole_seen || scan.dots >= 2'd2)
            scan.failed = 1'b1;
         else if (scan.dots == 2'd1 &&
                  (scan.mid_n == 3'd0 || scan.mid_n > dfp_pkg::GROUP_DIGITS))
            scan.failed = 1'b1;
         else
            scan.dots = scan.dots + 2'd1;
      end else begin
         scan.failed = 1'b1;
      end
   endtask

   function automatic reading_type close_text();
      reading_type r;
      logic [63:0] frac;
      r.ok    = 1'b0;
      r.hertz = 64'd0;
      frac    = 64'd0;
      if (scan.failed || !scan.whole_seen || scan.whole_ovf)
         return r;
      if (scan.dots == 2'd0) begin
         r.ok    = 1'b1;
         r.hertz = scan.whole;
         return r;
      end
      if (scan.whole > dfp_pkg::MHZ_MAX)
         return r;
      if (scan.dots == 2'd1) begin
         if (scan.mid_n == 3'd0 || scan.mid_n > dfp_pkg::FRAC_DIGITS)
            return r;
         frac = scan.mid * ten_to(int'(dfp_pkg::FRAC_DIGITS - scan.mid_n));
      end else begin
         if (scan.mid_n == 3'd0 || scan.mid_n > dfp_pkg::GROUP_DIGITS ||
             scan.low_n == 3'd0 || scan.low_n > dfp_pkg::GROUP_DIGITS)
            return r;
         frac = scan.mid * ten_to(int'(dfp_pkg::GROUP_DIGITS - scan.mid_n)) * HZ_PER_KHZ
              + scan.low * ten_to(int'(dfp_pkg::GROUP_DIGITS - scan.low_n));
      end
      r.ok    = 1'b1;
      r.hertz = scan.whole * dfp_pkg::HZ_PER_MHZ + frac;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Text composition helpers
   // ------------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] c);
      draft.push_back(c);
   endtask

   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++)
         draft.push_back(s[i]);
   endtask

   task automatic add_digits(input int n);
      for (int i = 0; i < n; i++)
         draft.push_back(dfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic add_blanks(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 5);
         draft.push_back((k == 5) ? dfp_pkg::CHAR_SPACE : dfp_pkg::CHAR_TAB + 8'(k));
      end
   endtask

   // Move the draft into the byte queue, flagging its final byte.
   task automatic flush_text(input logic hold);
      text_byte_type b;
      if (draft.size() == 0)
         draft.push_back(dfp_pkg::CHAR_SPACE);
      for (int i = 0; i < draft.size(); i++) begin
         b.code = draft[i];
         b.last = (i == draft.size() - 1);
         b.hold = hold && (i == 0);
         typed_bytes.push_back(b);
      end
      draft.delete();
   endtask

   function automatic int idle_odds();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 8;
         default: return 25;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: change inputs at the falling edge; hold valid and the
   // payload steady until the transaction is taken.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if ($urandom_range(0, 63) == 0)
            gap_pct <= idle_odds();
         if (req_valid && !req_took) begin
            // hold: transaction still waiting for ready
         end else if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (typed_bytes.size() == 0 ||
                      (typed_bytes[0].hold && awaited_readings.size() != 0)) begin
            // Pause until the parser has returned every outstanding reading.
            req_valid <= 1'b0;
         end else if (typed_bytes.size() >= CALM_TAIL && $urandom_range(0, 99) < gap_pct) begin
            req_valid <= 1'b0;
            gap_left  <= $urandom_range(0, 16);
         end else begin
            req_valid     <= 1'b1;
            req_char_code <= typed_bytes[0].code;
            req_is_last   <= typed_bytes[0].last;
            void'(typed_bytes.pop_front());
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response sink: random stall bursts, plus one long hold-off that lets
   // the pipeline fill and forces req_ready low.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if ($urandom_range(0, 63) == 0)
            stall_pct <= idle_odds();
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!long_hold_done && readings_seen >= 40) begin
            rsp_ready      <= 1'b0;
            hold_left      <= LONG_HOLD - 1;
            long_hold_done <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (typed_bytes.size() >= CALM_TAIL && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 16);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge. Advance the scanner
   // on each request transaction, check each response transaction against
   // the oldest awaited reading.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         req_took <= 1'b0;
         scan = blank_scan();
      end else begin
         req_took <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            scan_char(req_char_code);
            if (req_is_last) begin
               awaited_readings.push_back(close_text());
               scan = blank_scan();
            end
         end
         if (rsp_valid && rsp_ready) begin
            readings_seen <= readings_seen + 1;
            if (awaited_readings.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: ok=%0b hertz=%0d", rsp_ok, rsp_hertz);
            end else begin
               want = awaited_readings.pop_front();
               if (rsp_ok !== want.ok || rsp_hertz !== want.hertz) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("reading mismatch: expected ok=%0b hertz=%0d, got ok=%0b hertz=%0d",
                              want.ok, want.hertz, rsp_ok, rsp_hertz);
               end
            end
         end
      end
   end

   // Drop the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("decimal_frequency_text_parser_core_test: FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus: directed texts first, then random texts, then reset release
   // and the end-of-run drain.
   // ------------------------------------------------------------------------
   initial begin
      int text_count;
      int kind;
      int n;

      // Leading tab, digit, trailing carriage return: plain hertz.
      add_byte(dfp_pkg::CHAR_TAB); add_string("5"); add_byte(dfp_pkg::CHAR_CR);
      flush_text(1'b0);
      // Sign rejected.
      add_string("+7"); flush_text(1'b0);
      // Whitespace only.
      add_byte(dfp_pkg::CHAR_SPACE); flush_text(1'b0);
      // Dot with no whole part.
      add_byte(dfp_pkg::CHAR_DOT); flush_text(1'b0);
      // MHz with fraction.
      add_string("9.5"); flush_text(1'b0);
      // Empty fraction group.
      add_string("1."); flush_text(1'b0);
      // Inner whitespace.
      add_string("1 2"); flush_text(1'b0);
      // Non-breaking space and next-line bytes are not whitespace.
      add_byte(8'hA0); flush_text(1'b0);
      add_byte(8'h85); flush_text(1'b0);
      // MHz, kHz and Hz groups.
      add_string("1.2.3"); flush_text(1'b0);
      // Extremes of the byte range.
      add_byte(8'hFF); flush_text(1'b0);
      add_byte(8'h00); flush_text(1'b0);

      text_count = 0;
      while (typed_bytes.size() < 525) begin
         kind = $urandom_range(0, 19);
         if ($urandom_range(0, 2) == 0)
            add_blanks($urandom_range(1, 2));
         if (kind == 18)
            add_byte(($urandom_range(0, 1) == 0) ? "+" : "-");
         if (kind <= 4) begin
            // Plain hertz, now and then right at the 64-bit edge.
            case ($urandom_range(0, 11))
               0:       add_string("18446744073709551615");
               1:       add_string("18446744073709551616");
               2:       add_string("99999999999999999999");
               3:       begin add_string("1844674407370955161"); add_digits(1); end
               4:       add_digits($urandom_range(15, 21));
               default: add_digits($urandom_range(1, 8));
            endcase
         end else if (kind <= 18 || kind == 18) begin
            if (kind <= 16 || kind == 18) begin
               // Whole MHz part, including the range edge and leading zeros.
               case ($urandom_range(0, 9))
                  0:       add_string("9999");
                  1:       add_string("10000");
                  2:       begin add_string("000"); add_digits(1); end
                  3:       n = 0;
                  4:       add_digits($urandom_range(5, 6));
                  default: add_digits($urandom_range(1, 4));
               endcase
               add_byte(dfp_pkg::CHAR_DOT);
               if (kind >= 11 && kind <= 16) begin
                  n = $urandom_range(0, 10);
                  add_digits((n == 0) ? 0 : (n == 1) ? 4 : $urandom_range(1, 3));
                  add_byte(dfp_pkg::CHAR_DOT);
                  n = $urandom_range(0, 10);
                  add_digits((n == 0) ? 0 : (n == 1) ? 4 : $urandom_range(1, 3));
                  // Occasionally a third dot.
                  if ($urandom_range(0, 14) == 0) begin
                     add_byte(dfp_pkg::CHAR_DOT);
                     add_digits(1);
                  end
               end else begin
                  n = $urandom_range(0, 12);
                  add_digits((n == 0) ? 0 : (n == 1) ? 7 : $urandom_range(1, 6));
               end
            end else begin
               // Noise of arbitrary bytes.
               n = $urandom_range(1, 5);
               for (int i = 0; i < n; i++)
                  add_byte(8'($urandom_range(0, 255)));
            end
         end else begin
            add_blanks($urandom_range(1, 3));
         end
         if ($urandom_range(0, 2) == 0)
            add_blanks($urandom_range(1, 2));
         if (draft.size() == 0)
            add_byte(dfp_pkg::CHAR_SPACE);
         // Corrupt a few texts: one random byte, or an inserted space.
         if ($urandom_range(0, 11) == 0)
            draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
         else if ($urandom_range(0, 19) == 0)
            draft.insert($urandom_range(0, draft.size() - 1), dfp_pkg::CHAR_SPACE);
         flush_text(text_count % 45 == 0);
         text_count++;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: every byte taken and every reading returned, then settle.
      while (typed_bytes.size() != 0 || req_valid || awaited_readings.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatch_count == 0)
         $display("decimal_frequency_text_parser_core_test: PASS");
      else
         $display("decimal_frequency_text_parser_core_test: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/dfp_pkg.sv
hw/rtl/dfp_scanner.sv
hw/rtl/dfp_scale.sv
hw/rtl/decimal_frequency_text_parser_core.sv
verif/decimal_frequency_text_parser_core_test.sv
